@@ src/pacc_pkg.sv @@
// Shared types and constants for the phase accumulator with peak hold.
`timescale 1ns / 1ps

package pacc_pkg;

    localparam int unsigned PHASE_W = 24;
    localparam int unsigned HOLD_W  = 32;
    localparam int unsigned SHIFT_W = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Bit position of a one-sixteenth-turn phase shift
    localparam int unsigned SHIFT_POS = 20;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_HOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_HOLD   = 2'd2;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_SHIFT = 1'b1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_STEP_RESET = 24'd1;

    typedef struct packed {
        logic               mode;
        logic [SHIFT_W-1:0] shift_amount;
    } t_in_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               cycle_start;
    } t_out_item;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_step;
        logic [HOLD_W-1:0]  high_hold_ticks;
        logic [HOLD_W-1:0]  low_hold_ticks;
    } t_cfg;

endpackage

@@ src/pacc_core.sv @@
// Accumulator state and per-transaction update: add, wrap check and peak hold counters.
`timescale 1ns / 1ps

module pacc_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  pacc_pkg::t_in_item   i_item,
    input  pacc_pkg::t_cfg       i_cfg,
    output pacc_pkg::t_out_item  o_result
);

    logic [pacc_pkg::PHASE_W-1:0] r_phase, n_phase;
    logic [1:0]                   r_prev_quad, n_prev_quad;
    logic [pacc_pkg::HOLD_W-1:0]  r_high_left, n_high_left;
    logic [pacc_pkg::HOLD_W-1:0]  r_low_left, n_low_left;
    logic                         r_wrap, n_wrap;

    logic                         w_add_en;
    logic [pacc_pkg::PHASE_W:0]   w_addend;
    logic [pacc_pkg::PHASE_W:0]   w_sum;
    logic                         w_carry;
    logic [1:0]                   w_quad;

    always_comb begin
        if (i_item.mode == pacc_pkg::MODE_SHIFT) begin
            w_addend = {1'b0, i_item.shift_amount, {pacc_pkg::SHIFT_POS{1'b0}}};
        end else begin
            w_addend = {1'b0, i_cfg.phase_step};
        end
        w_sum   = {1'b0, r_phase} + w_addend;
        w_carry = w_sum[pacc_pkg::PHASE_W];
        w_quad  = w_carry ? pacc_pkg::QUAD_0 : w_sum[pacc_pkg::PHASE_W-1 -: 2];
    end

    always_comb begin
        n_phase     = r_phase;
        n_prev_quad = r_prev_quad;
        n_high_left = r_high_left;
        n_low_left  = r_low_left;
        n_wrap      = r_wrap;
        w_add_en    = 1'b0;

        if (i_item.mode == pacc_pkg::MODE_TICK) begin
            n_wrap = 1'b0;
            if (r_high_left != '0) begin
                n_high_left = r_high_left - 1'b1;
            end else if (r_low_left != '0) begin
                n_low_left = r_low_left - 1'b1;
            end else begin
                w_add_en = 1'b1;
            end
        end else begin
            w_add_en = 1'b1;
        end

        if (w_add_en) begin
            n_phase     = w_sum[pacc_pkg::PHASE_W-1:0];
            n_prev_quad = w_quad;
            if (w_carry) begin
                n_wrap = 1'b1;
            end else if (w_quad == pacc_pkg::QUAD_1 && r_prev_quad == pacc_pkg::QUAD_0) begin
                n_high_left = i_cfg.high_hold_ticks;
            end else if (w_quad == pacc_pkg::QUAD_3 && r_prev_quad == pacc_pkg::QUAD_2) begin
                n_low_left = i_cfg.low_hold_ticks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_prev_quad <= pacc_pkg::QUAD_0;
            r_high_left <= '0;
            r_low_left  <= '0;
            r_wrap      <= 1'b0;
        end else if (i_advance) begin
            r_phase     <= n_phase;
            r_prev_quad <= n_prev_quad;
            r_high_left <= n_high_left;
            r_low_left  <= n_low_left;
            r_wrap      <= n_wrap;
        end
    end

    assign o_result.phase       = n_phase;
    assign o_result.cycle_start = n_wrap;

    // A tick that only counts down the high hold must leave the phase where it is
    a_hold_freezes_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == pacc_pkg::MODE_TICK && r_high_left != '0
        |=> $stable(r_phase))
        else $error("phase moved during high hold");

    // A wrap resets the quadrant tracking and raises the start flag
    a_wrap_clears_quad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && w_add_en && w_carry
        |=> r_wrap && r_prev_quad == pacc_pkg::QUAD_0)
        else $error("wrap did not set flag and clear quadrant");

    // A tick without a wrap always drops the start flag
    a_tick_drops_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && i_item.mode == pacc_pkg::MODE_TICK && !(w_add_en && w_carry)
        |=> !r_wrap)
        else $error("start flag survived a tick");

    // A wrapping add leaves both hold counters untouched
    a_single_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && w_add_en && w_carry
        |=> $stable(r_high_left) && $stable(r_low_left))
        else $error("hold counter loaded on a wrap");

endmodule

@@ src/phase_accumulator_with_peak_hold_unit.sv @@
// Top level: configuration registers, input handshake and registered result output.
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready        | i_in  (mode, shift_amount)
//  out     | output    | o_out_valid / i_out_ready      | o_out (phase, cycle_start)
//  cfg     | input     | i_cfg_we, i_cfg_idx            | i_cfg_data
//
//  One transaction per cycle while the output is drained; the result is registered in the cycle after
//  acceptance, from the single 25-bit add and quadrant compare ahead of the output register.
//  Input is taken whenever the output register is empty or is being drained.
//  A stalled output holds its result and blocks further input only while full.
//  Synchronous active-low reset clears the accumulator state, the output valid and
//  loads phase_step = 1 and both hold counts with zero.
`timescale 1ns / 1ps

module phase_accumulator_with_peak_hold_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  pacc_pkg::t_in_item                  i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output pacc_pkg::t_out_item                 o_out,
    input  logic                                i_cfg_we,
    input  logic [pacc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pacc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pacc_pkg::t_cfg      r_cfg;
    pacc_pkg::t_out_item r_out;
    logic                r_out_valid;
    pacc_pkg::t_out_item w_result;
    logic                w_accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.phase_step      <= pacc_pkg::PHASE_STEP_RESET;
            r_cfg.high_hold_ticks <= '0;
            r_cfg.low_hold_ticks  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                pacc_pkg::REG_PHASE_STEP:
                    r_cfg.phase_step <= i_cfg_data[pacc_pkg::PHASE_W-1:0];
                pacc_pkg::REG_HIGH_HOLD:
                    r_cfg.high_hold_ticks <= i_cfg_data[pacc_pkg::HOLD_W-1:0];
                pacc_pkg::REG_LOW_HOLD:
                    r_cfg.low_hold_ticks <= i_cfg_data[pacc_pkg::HOLD_W-1:0];
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    pacc_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept),
        .i_item    (i_in),
        .i_cfg     (r_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ verif/pacc_result_checker.sv @@
// Result checker for the phase accumulator: tracks configuration, predicts and compares.
`timescale 1ns / 1ps

module pacc_result_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  pacc_pkg::t_in_item              i_in,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  pacc_pkg::t_out_item             i_out,
    input  logic                            i_cfg_we,
    input  logic [pacc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pacc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);

    // Mirrored configuration
    logic [pacc_pkg::PHASE_W-1:0] step_cfg;
    logic [pacc_pkg::HOLD_W-1:0]  high_ticks_cfg;
    logic [pacc_pkg::HOLD_W-1:0]  low_ticks_cfg;

    // Mirrored accumulator state
    logic [pacc_pkg::PHASE_W-1:0] acc;
    logic [1:0]                   last_quad;
    logic [pacc_pkg::HOLD_W-1:0]  high_left;
    logic [pacc_pkg::HOLD_W-1:0]  low_left;
    logic                         wrapped;

    pacc_pkg::t_out_item due_results[$];
    pacc_pkg::t_out_item want;

    task automatic report_mismatch(input string what);
        o_errors++;
        $display("[%0t] checker: %s", $realtime, what);
    endtask

    // Store the sum, then flag a wrap or load a hold counter on an exact peak crossing.
    function automatic void settle_phase(input logic [pacc_pkg::PHASE_W:0] sum);
        logic [2:0] quad;
        quad = sum[pacc_pkg::PHASE_W:pacc_pkg::PHASE_W-2];
        acc  = sum[pacc_pkg::PHASE_W-1:0];
        if (quad[2]) begin
            wrapped   = 1'b1;
            last_quad = pacc_pkg::QUAD_0;
        end else begin
            if (quad[1:0] == pacc_pkg::QUAD_1 && last_quad == pacc_pkg::QUAD_0)
                high_left = high_ticks_cfg;
            else if (quad[1:0] == pacc_pkg::QUAD_3 && last_quad == pacc_pkg::QUAD_2)
                low_left = low_ticks_cfg;
            last_quad = quad[1:0];
        end
    endfunction

    function automatic pacc_pkg::t_out_item step_accumulator(input pacc_pkg::t_in_item item);
        pacc_pkg::t_out_item res;
        if (item.mode == pacc_pkg::MODE_TICK) begin
            wrapped = 1'b0;
            if (high_left != '0)
                high_left--;
            else if (low_left != '0)
                low_left--;
            else
                settle_phase({1'b0, acc} + {1'b0, step_cfg});
        end else begin
            settle_phase({1'b0, acc} + ((pacc_pkg::PHASE_W+1)'(item.shift_amount)
                                        << pacc_pkg::SHIFT_POS));
        end
        res.phase       = acc;
        res.cycle_start = wrapped;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_errors       = 0;
            step_cfg       = pacc_pkg::PHASE_STEP_RESET;
            high_ticks_cfg = '0;
            low_ticks_cfg  = '0;
            acc            = '0;
            last_quad      = pacc_pkg::QUAD_0;
            high_left      = '0;
            low_left       = '0;
            wrapped        = 1'b0;
            due_results.delete();
        end else begin
            // A result leaving now always belongs to an earlier transaction.
            if (i_out_valid && i_out_ready) begin
                if (due_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result phase=%h start=%b",
                                              i_out.phase, i_out.cycle_start));
                end else begin
                    want = due_results.pop_front();
                    if (i_out.phase !== want.phase)
                        report_mismatch($sformatf("phase %h, expected %h",
                                                  i_out.phase, want.phase));
                    if (i_out.cycle_start !== want.cycle_start)
                        report_mismatch($sformatf("cycle_start %b, expected %b (phase %h)",
                                                  i_out.cycle_start, want.cycle_start,
                                                  want.phase));
                end
            end
            if (i_in_valid && i_in_ready)
                due_results.push_back(step_accumulator(i_in));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pacc_pkg::REG_PHASE_STEP:
                        step_cfg = i_cfg_data[pacc_pkg::PHASE_W-1:0];
                    pacc_pkg::REG_HIGH_HOLD:
                        high_ticks_cfg = i_cfg_data[pacc_pkg::HOLD_W-1:0];
                    pacc_pkg::REG_LOW_HOLD:
                        low_ticks_cfg = i_cfg_data[pacc_pkg::HOLD_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = due_results.size();
    end

endmodule

@@ verif/phase_accumulator_with_peak_hold_unit_tb.sv @@
// Testbench top: clock, reset, stimulus, output stalls and the final verdict.
`timescale 1ns / 1ps

module phase_accumulator_with_peak_hold_unit_tb;

    localparam int                             CYCLE_LIMIT   = 400000;
    localparam int                             RANDOM_ROUNDS = 6;
    localparam int                             ROUND_ITEMS   = 200;
    localparam logic [pacc_pkg::CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam logic [pacc_pkg::SHIFT_W-1:0]   QUARTER_TURN  = 4'd4;
    localparam logic [pacc_pkg::HOLD_W-1:0]    HOLD_MAX      = '1;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            in_valid  = 1'b0;
    logic                            in_ready;
    pacc_pkg::t_in_item              in_item   = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    pacc_pkg::t_out_item             out_item;
    logic                            cfg_we    = 1'b0;
    logic [pacc_pkg::CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [pacc_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    int failures;
    int pending;
    int cycle_count = 0;

    int unsigned burst_left  = 0;
    int unsigned ready_window = 0;
    logic [7:0]  ready_mask  = 8'hFF;
    logic [2:0]  ready_slot  = '0;

    always #5 clk = ~clk;

    phase_accumulator_with_peak_hold_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pacc_result_checker i_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in        (in_item),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_errors    (failures),
        .o_pending   (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver stalls: out_ready follows an 8-bit ready mask, redrawn when its window runs out.
    always @(negedge clk) begin
        if (ready_window == 0) begin
            ready_mask   = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom | 1);
            ready_window = $urandom_range(16, 64);
        end
        ready_window--;
        out_ready <= ready_mask[ready_slot];
        ready_slot++;
    end

    function automatic pacc_pkg::t_in_item tick_item();
        pacc_pkg::t_in_item item;
        item.mode         = pacc_pkg::MODE_TICK;
        item.shift_amount = (pacc_pkg::SHIFT_W)'($urandom);
        return item;
    endfunction

    function automatic pacc_pkg::t_in_item shift_item(
        input logic [pacc_pkg::SHIFT_W-1:0] amount);
        pacc_pkg::t_in_item item;
        item.mode         = pacc_pkg::MODE_SHIFT;
        item.shift_amount = amount;
        return item;
    endfunction

    // Present one transaction at a falling edge and hold it until accepted.
    task automatic drive_item(input pacc_pkg::t_in_item item);
        int unsigned gap;
        in_valid <= 1'b1;
        in_item  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (burst_left <= 1) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
            burst_left = $urandom_range(1, 24);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [pacc_pkg::CFG_IDX_W-1:0]  idx,
                             input logic [pacc_pkg::CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(negedge clk);
    endtask

    task automatic program_regs(input logic [pacc_pkg::CFG_DATA_W-1:0] step_word,
                                input logic [pacc_pkg::HOLD_W-1:0]     high_ticks,
                                input logic [pacc_pkg::HOLD_W-1:0]     low_ticks);
        write_reg(pacc_pkg::REG_PHASE_STEP, step_word);
        write_reg(pacc_pkg::REG_HIGH_HOLD, high_ticks);
        write_reg(pacc_pkg::REG_LOW_HOLD, low_ticks);
        write_reg(REG_UNUSED, $urandom);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Mostly ticks and quarter-turn walks that can cross the peaks, plus stray shifts.
    task automatic run_random(input int count);
        int sent;
        int pick;
        int len;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                drive_item(tick_item());
                sent++;
            end else if (pick < 72) begin
                len = $urandom_range(2, 20);
                repeat (len) drive_item(tick_item());
                sent += len;
            end else if (pick < 88) begin
                len = $urandom_range(1, 6);
                repeat (len) drive_item(shift_item(QUARTER_TURN));
                sent += len;
            end else begin
                drive_item(shift_item((pacc_pkg::SHIFT_W)'($urandom)));
                sent++;
            end
        end
    endtask

    initial begin
        logic [pacc_pkg::PHASE_W-1:0] step;
        logic [pacc_pkg::HOLD_W-1:0]  high_ticks;
        logic [pacc_pkg::HOLD_W-1:0]  low_ticks;
        int                           pick;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: tiny step, no holds; skipped quadrant, wrap, full walk
        drive_item(tick_item());
        drive_item(tick_item());
        drive_item(shift_item(4'd0));
        drive_item(shift_item(4'd15));
        drive_item(shift_item(4'd1));
        drive_item(tick_item());
        repeat (4) drive_item(shift_item(QUARTER_TURN));
        wait_idle();

        // Largest step with junk in the unused bits; short holds, reload during a hold
        program_regs({8'hA5, 24'hFF_FFFF}, 32'd3, 32'd2);
        drive_item(tick_item());
        drive_item(shift_item(QUARTER_TURN));
        repeat (2) drive_item(tick_item());
        drive_item(shift_item(4'd12));
        drive_item(shift_item(QUARTER_TURN));
        repeat (4) drive_item(tick_item());
        drive_item(shift_item(4'd8));
        drive_item(shift_item(QUARTER_TURN));
        repeat (3) drive_item(tick_item());
        wait_idle();

        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            if (round == 0) begin
                // Zero step with the longest holds: ticks only count down
                step       = '0;
                high_ticks = HOLD_MAX;
                low_ticks  = HOLD_MAX;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    step = (pacc_pkg::PHASE_W)'($urandom_range(1 << 18, 1 << 21));
                else if (pick < 8)
                    step = (pacc_pkg::PHASE_W)'($urandom);
                else if (pick == 8)
                    step = '1;
                else
                    step = pacc_pkg::PHASE_STEP_RESET;
                high_ticks = ($urandom_range(0, 4) == 0) ? '0 : $urandom_range(1, 12);
                low_ticks  = ($urandom_range(0, 4) == 0) ? '0 : $urandom_range(1, 12);
                if (round == RANDOM_ROUNDS - 1) begin
                    high_ticks = '0;
                    low_ticks  = '0;
                end
            end
            program_regs({8'($urandom), step}, high_ticks, low_ticks);
            run_random(ROUND_ITEMS);
            wait_idle();
        end

        repeat (5) @(posedge clk);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
